// ----- rtl/grcw_pkg.sv -----
// Shared constants, sizes and the quarter-wave sine table of the grid ray cell walker.
// No dependencies; imported by grid_ray_cell_walk_core.
package grcw_pkg;

   // Grid geometry
   localparam int GRID_CELLS   = 8;
   localparam int GRID_BITS    = $clog2(GRID_CELLS);
   localparam int GALAXY_QUADS = 8;
   localparam int GALAXY_CELLS = GALAXY_QUADS * GRID_CELLS;
   localparam int COORD_W      = $clog2(GALAXY_CELLS);

   // Port field widths
   localparam int FIELD_W  = 3;
   localparam int WARP_W   = 8;
   localparam int COURSE_W = 7;

   // Heading: course in 1/2^F of 45 degrees
   localparam int COURSE_FRACTION_BITS = 4;
   localparam int QUARTER   = 2 << COURSE_FRACTION_BITS;
   localparam int R_W       = COURSE_FRACTION_BITS + 1;
   localparam int ROM_IDX_W = $clog2(QUARTER + 1);

   // Direction magnitudes are Q1.15, 0..UNIT
   localparam int UNIT_SHIFT = 15;
   localparam int UNIT       = 1 << UNIT_SHIFT;
   localparam int MAG_W      = UNIT_SHIFT + 1;

   // Distance in cells: round(min(warp, cap) * GRID_CELLS / 16)
   localparam int WARP_CAP  = 128;
   localparam int WARP_FRAC = 4;
   localparam int SCALED_W  = WARP_W + GRID_BITS + 1;
   localparam int D_MAX     = (WARP_CAP * GRID_CELLS + (1 << (WARP_FRAC - 1))) >> WARP_FRAC;
   localparam int D_W       = $clog2(D_MAX + 1);
   localparam int BIT_W     = $clog2(D_W);

   // Crossing counters, products and signed positions
   localparam int N_W    = $clog2(D_MAX + 2);
   localparam int PROD_W = $clog2(D_MAX * UNIT + 1);
   localparam int LIM_W  = PROD_W - UNIT_SHIFT;
   localparam int ALU_W  = PROD_W + 1;
   localparam int POS_W  = N_W + 2;

   // Result limit
   localparam int MAX_CELLS_OUT = 64;
   localparam int CNT_W         = $clog2(MAX_CELLS_OUT + 1);

   // Q30 sine series coefficients in a quarter-turn variable
   localparam logic [63:0] SC1 = 64'd1686629713;
   localparam logic [63:0] SC3 = 64'd693598668;
   localparam logic [63:0] SC5 = 64'd85569306;
   localparam logic [63:0] SC7 = 64'd5026998;
   localparam logic [63:0] SC9 = 64'd172272;

   typedef logic [MAG_W-1:0] sine_rom_type [QUARTER+1];

   // Horner evaluation, each product truncated, rounded half up to Q15
   function automatic logic [MAG_W-1:0] sine_q15(input int k);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] p;
      logic [63:0] s;
      z  = 64'(k) << (29 - COURSE_FRACTION_BITS);
      z2 = (z * z) >> 30;
      p  = SC9;
      p  = SC7 - ((z2 * p) >> 30);
      p  = SC5 - ((z2 * p) >> 30);
      p  = SC3 - ((z2 * p) >> 30);
      p  = SC1 - ((z2 * p) >> 30);
      s  = (z * p) >> 30;
      s  = (s + 64'(1 << 14)) >> 15;
      if (s > 64'(UNIT)) begin
         return MAG_W'(UNIT);
      end
      return s[MAG_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type t;
      for (int i = 0; i <= QUARTER; i++) begin
         t[i] = sine_q15(i);
      end
      return t;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/grid_ray_cell_walk_core.sv -----
// Grid ray cell walker: steps a ray across a 64x64 cell grid and reports each entered cell.
// Depends on grcw_pkg (sizes, sine table).
//
//  chan  dir  handshake            payload
//  req   in   req_valid/req_ready  start quadrant x/y, start sector x/y, warp_sixteenths, course
//  rsp   out  rsp_valid/rsp_ready  sector x/y, quadrant x/y, cell_valid, truncated, last
//
// Sequence: after the request transfer, shift-add for d*ax and d*ay and then the initial
//   crossing-time difference, all on the one shared 23-bit adder; then each boundary move
//   is a step and then a check. A walk makes at most 2*(D_MAX+1) boundary moves.
// req_ready is high only in idle; one request is walked at a time.
// A result waits in the output register; the walk stalls only when it must hand over a cell
//   while that register is still full.
// Reset (synchronous, active high) clears the sequencer and the output valid flag.
module grid_ray_cell_walk_core import grcw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [FIELD_W-1:0] req_start_quadrant_x,
   input  logic [FIELD_W-1:0] req_start_quadrant_y,
   input  logic [FIELD_W-1:0] req_start_sector_x,
   input  logic [FIELD_W-1:0] req_start_sector_y,
   input  logic [WARP_W-1:0]  req_warp_sixteenths,
   input  logic [COURSE_W-1:0] req_course,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIELD_W-1:0] rsp_sector_x,
   output logic [FIELD_W-1:0] rsp_sector_y,
   output logic [FIELD_W-1:0] rsp_quadrant_x,
   output logic [FIELD_W-1:0] rsp_quadrant_y,
   output logic               rsp_cell_valid,
   output logic               rsp_truncated,
   output logic               rsp_last
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MUL_X  = 7'b0000010,
      ST_MUL_Y  = 7'b0000100,
      ST_INIT   = 7'b0001000,
      ST_WALK   = 7'b0010000,
      ST_CHECK  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } walk_state_type;

   // heading quadrant: x moves along +cos, y along -sin
   typedef enum logic [1:0] {
      HDG_XP_YN = 2'd0,
      HDG_XN_YN = 2'd1,
      HDG_XN_YP = 2'd2,
      HDG_XP_YP = 2'd3
   } heading_type;

   walk_state_type state_ff, state_in;

   // request parameters
   logic [COORD_W-1:0] x0_ff, x0_in, y0_ff, y0_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic [MAG_W-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic               xneg_ff, xneg_in, yneg_ff, yneg_in;

   // shift-add multiply
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [LIM_W-1:0]   lim_x_ff, lim_x_in, lim_y_ff, lim_y_in;
   logic               exact_x_ff, exact_x_in, exact_y_ff, exact_y_in;

   // walk state: diff = nx*ay - ny*ax, diag = ay - ax
   logic [ALU_W-1:0]   diff_ff, diff_in, diag_ff, diag_in;
   logic [N_W-1:0]     nx_ff, nx_in, ny_ff, ny_in;
   logic [POS_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic               at_end_ff, at_end_in;
   logic [COORD_W-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] sec_x_ff, sec_x_in, sec_y_ff, sec_y_in;
   logic [FIELD_W-1:0] quad_x_ff, quad_x_in, quad_y_ff, quad_y_in;
   logic               cell_valid_ff, cell_valid_in;
   logic               trunc_ff, trunc_in;
   logic               last_ff, last_in;
   logic               load_out, out_free;

   // shared adder
   logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
   logic               alu_sub;

   // request decode
   logic [COORD_W-1:0]   x0_new, y0_new;
   logic [WARP_W-1:0]    warp_cap;
   logic [SCALED_W-1:0]  d_scaled;
   logic [D_W-1:0]       d_new;
   logic [ROM_IDX_W-1:0] rom_s_idx, rom_c_idx;
   logic [MAG_W-1:0]     sin_mag, cos_mag;
   heading_type          heading;

   // move decode
   logic               hx, hy, tx, ty, ax_nz, ay_nz, diff_le0, diff_ge0;
   logic [N_W-1:0]     off_x, off_y;
   logic               outside, fresh;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sector_x   = sec_x_ff;
   assign rsp_sector_y   = sec_y_ff;
   assign rsp_quadrant_x = quad_x_ff;
   assign rsp_quadrant_y = quad_y_ff;
   assign rsp_cell_valid = cell_valid_ff;
   assign rsp_truncated  = trunc_ff;
   assign rsp_last       = last_ff;

   // --- request decode: start point, distance, direction from the sine table ---
   always_comb begin
      x0_new = COORD_W'(req_start_quadrant_x) * COORD_W'(GRID_CELLS)
             + COORD_W'(req_start_sector_x);
      y0_new = COORD_W'(req_start_quadrant_y) * COORD_W'(GRID_CELLS)
             + COORD_W'(req_start_sector_y);
      warp_cap = (req_warp_sixteenths > WARP_W'(WARP_CAP)) ? WARP_W'(WARP_CAP)
                                                            : req_warp_sixteenths;
      d_scaled = SCALED_W'(warp_cap) * SCALED_W'(GRID_CELLS)
               + SCALED_W'(1 << (WARP_FRAC - 1));
      d_new    = D_W'(d_scaled >> WARP_FRAC);
      rom_s_idx = ROM_IDX_W'(req_course[R_W-1:0]);
      rom_c_idx = ROM_IDX_W'(QUARTER) - rom_s_idx;
      sin_mag   = SINE_ROM[rom_s_idx];
      cos_mag   = SINE_ROM[rom_c_idx];
      heading   = heading_type'(req_course[R_W+1:R_W]);
   end

   // --- move decode: which boundary comes next ---
   always_comb begin
      ax_nz    = (ax_ff != '0);
      ay_nz    = (ay_ff != '0);
      diff_le0 = diff_ff[ALU_W-1] || (diff_ff == '0);
      diff_ge0 = !diff_ff[ALU_W-1];
      // nx*UNIT <= d*ax  <=>  nx <= floor(d*ax / UNIT); false when ax is zero
      hx = (nx_ff <= N_W'(lim_x_ff));
      hy = (ny_ff <= N_W'(lim_y_ff));
      tx = hx && (!hy || diff_le0);
      ty = hy && (!hx || diff_ge0);
      // off-axis coordinate lies in [n-1, n): floor n-1, ceiling n (n-1 when still)
      off_x = (tx || (xneg_ff && ax_nz)) ? nx_ff : nx_ff - N_W'(1);
      off_y = (ty || (yneg_ff && ay_nz)) ? ny_ff : ny_ff - N_W'(1);
   end

   // --- shared adder operand select ---
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_MUL_X: begin
            alu_a = {acc_ff, 1'b0};
            alu_b = d_ff[bit_ff] ? ALU_W'(ax_ff) : '0;
         end
         ST_MUL_Y: begin
            alu_a = {acc_ff, 1'b0};
            alu_b = d_ff[bit_ff] ? ALU_W'(ay_ff) : '0;
         end
         ST_INIT: begin
            alu_a   = ALU_W'(ay_ff);
            alu_b   = ALU_W'(ax_ff);
            alu_sub = 1'b1;
         end
         ST_WALK: begin
            alu_a = diff_ff;
            if (tx && ty) begin
               alu_b = diag_ff;
            end else if (tx) begin
               alu_b = ALU_W'(ay_ff);
            end else begin
               alu_b   = ALU_W'(ax_ff);
               alu_sub = ty;
            end
         end
         default: begin
            alu_a = '0;
         end
      endcase
      alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
   end

   // --- sequencer ---
   always_comb begin
      state_in   = state_ff;
      x0_in      = x0_ff;
      y0_in      = y0_ff;
      d_in       = d_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      xneg_in    = xneg_ff;
      yneg_in    = yneg_ff;
      bit_in     = bit_ff;
      acc_in     = acc_ff;
      lim_x_in   = lim_x_ff;
      lim_y_in   = lim_y_ff;
      exact_x_in = exact_x_ff;
      exact_y_in = exact_y_ff;
      diff_in    = diff_ff;
      diag_in    = diag_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      at_end_in  = at_end_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      cnt_in     = cnt_ff;

      load_out      = 1'b0;
      sec_x_in      = last_x_ff[GRID_BITS-1:0];
      sec_y_in      = last_y_ff[GRID_BITS-1:0];
      quad_x_in     = last_x_ff[COORD_W-1:GRID_BITS];
      quad_y_in     = last_y_ff[COORD_W-1:GRID_BITS];
      cell_valid_in = 1'b1;
      trunc_in      = 1'b0;
      last_in       = 1'b0;

      // a point outside the grid, or one that has moved to a new cell
      outside = px_ff[POS_W-1] || (px_ff[POS_W-2:COORD_W] != '0)
             || py_ff[POS_W-1] || (py_ff[POS_W-2:COORD_W] != '0);
      fresh   = (px_ff[COORD_W-1:0] != last_x_ff) || (py_ff[COORD_W-1:0] != last_y_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x0_in     = x0_new;
               y0_in     = y0_new;
               last_x_in = x0_new;
               last_y_in = y0_new;
               d_in      = d_new;
               acc_in    = '0;
               bit_in    = BIT_W'(D_W - 1);
               cnt_in    = '0;
               nx_in     = N_W'(1);
               ny_in     = N_W'(1);
               unique case (heading)
                  HDG_XP_YN: begin
                     ax_in = cos_mag; xneg_in = 1'b0; ay_in = sin_mag; yneg_in = 1'b1;
                  end
                  HDG_XN_YN: begin
                     ax_in = sin_mag; xneg_in = 1'b1; ay_in = cos_mag; yneg_in = 1'b1;
                  end
                  HDG_XN_YP: begin
                     ax_in = cos_mag; xneg_in = 1'b1; ay_in = sin_mag; yneg_in = 1'b0;
                  end
                  HDG_XP_YP: begin
                     ax_in = sin_mag; xneg_in = 1'b0; ay_in = cos_mag; yneg_in = 1'b0;
                  end
                  default: begin
                     ax_in = sin_mag; xneg_in = 1'b0; ay_in = cos_mag; yneg_in = 1'b0;
                  end
               endcase
               state_in = (d_new == '0) ? ST_FINISH : ST_MUL_X;
            end
         end

         // d*ax, MSB first
         ST_MUL_X: begin
            acc_in = alu_sum[PROD_W-1:0];
            if (bit_ff == '0) begin
               lim_x_in   = alu_sum[PROD_W-1:UNIT_SHIFT];
               exact_x_in = (alu_sum[UNIT_SHIFT-1:0] == '0);
               acc_in     = '0;
               bit_in     = BIT_W'(D_W - 1);
               state_in   = ST_MUL_Y;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end

         ST_MUL_Y: begin
            acc_in = alu_sum[PROD_W-1:0];
            if (bit_ff == '0) begin
               lim_y_in   = alu_sum[PROD_W-1:UNIT_SHIFT];
               exact_y_in = (alu_sum[UNIT_SHIFT-1:0] == '0);
               state_in   = ST_INIT;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end

         ST_INIT: begin
            diff_in  = alu_sum;
            diag_in  = alu_sum;
            state_in = ST_WALK;
         end

         // one boundary move: end point, end flag, crossing counters
         ST_WALK: begin
            px_in = xneg_ff ? POS_W'(x0_ff) - POS_W'(off_x) : POS_W'(x0_ff) + POS_W'(off_x);
            py_in = yneg_ff ? POS_W'(y0_ff) - POS_W'(off_y) : POS_W'(y0_ff) + POS_W'(off_y);
            if (!hx && !hy) begin
               at_end_in = 1'b1;
            end else if (tx) begin
               at_end_in = (nx_ff == N_W'(lim_x_ff)) && exact_x_ff;
            end else begin
               at_end_in = (ny_ff == N_W'(lim_y_ff)) && exact_y_ff;
            end
            if (tx || ty) begin
               diff_in = alu_sum;
            end
            nx_in    = nx_ff + N_W'(tx);
            ny_in    = ny_ff + N_W'(ty);
            state_in = ST_CHECK;
         end

         // bounds, new-cell test; the held cell goes out once the next is known
         ST_CHECK: begin
            if (outside) begin
               state_in = ST_FINISH;
            end else if (fresh) begin
               if (cnt_ff == '0) begin
                  last_x_in = px_ff[COORD_W-1:0];
                  last_y_in = py_ff[COORD_W-1:0];
                  cnt_in    = CNT_W'(1);
                  state_in  = at_end_ff ? ST_FINISH : ST_WALK;
               end else if (out_free) begin
                  load_out = 1'b1;
                  if (cnt_ff == CNT_W'(MAX_CELLS_OUT)) begin
                     // one cell past the limit: close with the truncation flag
                     trunc_in = 1'b1;
                     last_in  = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     last_x_in = px_ff[COORD_W-1:0];
                     last_y_in = py_ff[COORD_W-1:0];
                     cnt_in    = cnt_ff + CNT_W'(1);
                     state_in  = at_end_ff ? ST_FINISH : ST_WALK;
                  end
               end
            end else begin
               state_in = at_end_ff ? ST_FINISH : ST_WALK;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               load_out = 1'b1;
               last_in  = 1'b1;
               if (cnt_ff == '0) begin
                  // empty path
                  sec_x_in      = '0;
                  sec_y_in      = '0;
                  quad_x_in     = '0;
                  quad_y_in     = '0;
                  cell_valid_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);
   end

   // --- control registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // --- datapath registers ---
   always_ff @(posedge clock) begin
      x0_ff      <= x0_in;
      y0_ff      <= y0_in;
      d_ff       <= d_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      xneg_ff    <= xneg_in;
      yneg_ff    <= yneg_in;
      bit_ff     <= bit_in;
      acc_ff     <= acc_in;
      lim_x_ff   <= lim_x_in;
      lim_y_ff   <= lim_y_in;
      exact_x_ff <= exact_x_in;
      exact_y_ff <= exact_y_in;
      diff_ff    <= diff_in;
      diag_ff    <= diag_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      at_end_ff  <= at_end_in;
      last_x_ff  <= last_x_in;
      last_y_ff  <= last_y_in;
      cnt_ff     <= cnt_in;
      if (load_out) begin
         sec_x_ff      <= sec_x_in;
         sec_y_ff      <= sec_y_in;
         quad_x_ff     <= quad_x_in;
         quad_y_ff     <= quad_y_in;
         cell_valid_ff <= cell_valid_in;
         trunc_ff      <= trunc_in;
         last_ff       <= last_in;
      end
   end

endmodule
